[rtl/core/bit_packed_array_store_top_macros.svh]
// ----------------------------------------------------------------------------
// Bit-packed array store: assertion macros
// Shared property forms for the checker of the store's top level.
// ----------------------------------------------------------------------------
`ifndef BIT_PACKED_ARRAY_STORE_TOP_MACROS_SVH
`define BIT_PACKED_ARRAY_STORE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BPAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BPAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bpas_pkg.sv]
// ----------------------------------------------------------------------------
// Bit-packed array store package
// Sizes, types, codes and command format shared by the store's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpas_pkg;

  // Array geometry.
  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned WORD_COUNT   = MAX_ELEMENTS + 1;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned WIDTH_W      = 7;
  localparam int unsigned OFF_W        = 6;
  localparam int unsigned POS_W        = IDX_W + OFF_W;
  localparam int unsigned ADDR_W       = $clog2(WORD_COUNT);

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DATA_W-1:0]        data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [IDX_W:0]           idx_ext_t;
  typedef logic [WIDTH_W-1:0]       width_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [IDX_W+WIDTH_W-1:0] prod_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [PDATA_W-1:0]       pdata_t;
  typedef logic [QPTR_W-1:0]        qptr_t;
  typedef logic [QCNT_W-1:0]        qcnt_t;

  localparam data_t  ALL_ONES     = '1;
  localparam width_t WIDTH_RESET  = width_t'(8);
  localparam logic   SIGNED_RESET = 1'b0;
  localparam addr_t  CLEAR_LAST   = addr_t'(WORD_COUNT - 1);
  localparam qcnt_t  QUEUE_FULL   = qcnt_t'(QUEUE_DEPTH);

  // Request opcodes.
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_STORED_WIDTH = 1'b0,
    REG_SIGNED_MODE  = 1'b1
  } reg_idx_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } back_state_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    op_t   op;
    logic  skip;
    logic  sgn;
    logic  straddle;
    idx_t  word;
    off_t  off;
    off_t  lo;
    data_t mask;
    data_t value;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/bpas_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpas_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/bpas_front.sv]
// ----------------------------------------------------------------------------
// Bit-packed array store: front end
// Accepts requests, works out word, offset and split of the element, and
// queues the classified command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpas_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  input  bpas_pkg::idx_t         in_element_index,
  input  logic signed [63:0]     in_write_value,
  input  bpas_pkg::width_t       stored_width,
  input  logic                   signed_mode,
  input  logic                   clearing,
  output logic                   q_valid,
  output bpas_pkg::cmd_t         q_cmd,
  input  logic                   q_pop
);

  bpas_pkg::width_t w_eff;
  bpas_pkg::prod_t  prod;
  bpas_pkg::pos_t   pos;
  bpas_pkg::width_t end_sum;
  bpas_pkg::data_t  mask;
  bpas_pkg::cmd_t   cmd_in;

  bpas_pkg::cmd_t   q_mem_r [bpas_pkg::QUEUE_DEPTH];
  bpas_pkg::qptr_t  wr_ptr_r, wr_ptr_nxt;
  bpas_pkg::qptr_t  rd_ptr_r, rd_ptr_nxt;
  bpas_pkg::qcnt_t  cnt_r, cnt_nxt;
  logic             push;

  // Effective width: zero counts as one, anything above a word as a word.
  always_comb begin
    priority if (stored_width == '0) begin
      w_eff = bpas_pkg::width_t'(1);
    end else if (stored_width > bpas_pkg::width_t'(bpas_pkg::DATA_W)) begin
      w_eff = bpas_pkg::width_t'(bpas_pkg::DATA_W);
    end else begin
      w_eff = stored_width;
    end
  end

  // Bit position of the element and whether it runs into the next word.
  assign prod    = bpas_pkg::prod_t'(in_element_index) * bpas_pkg::prod_t'(w_eff);
  assign pos     = prod[bpas_pkg::POS_W-1:0];
  assign end_sum = bpas_pkg::width_t'(pos[bpas_pkg::OFF_W-1:0]) + w_eff;
  assign mask    = bpas_pkg::ALL_ONES >> (bpas_pkg::width_t'(bpas_pkg::DATA_W) - w_eff);

  // Classified command.
  always_comb begin
    cmd_in.op       = bpas_pkg::op_t'(in_opcode);
    cmd_in.skip     = bpas_pkg::idx_ext_t'(in_element_index)
                      >= bpas_pkg::idx_ext_t'(bpas_pkg::MAX_ELEMENTS);
    cmd_in.sgn      = signed_mode;
    cmd_in.straddle = end_sum > bpas_pkg::width_t'(bpas_pkg::DATA_W);
    cmd_in.word     = pos[bpas_pkg::POS_W-1:bpas_pkg::OFF_W];
    cmd_in.off      = pos[bpas_pkg::OFF_W-1:0];
    // Bits past the word boundary; only meaningful for a split element.
    cmd_in.lo       = end_sum[bpas_pkg::OFF_W-1:0];
    cmd_in.mask     = mask;
    cmd_in.value    = in_write_value & mask;
  end

  // Queue handshake.
  assign in_ready = !clearing && (cnt_r != bpas_pkg::QUEUE_FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != '0;
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + bpas_pkg::qptr_t'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + bpas_pkg::qptr_t'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + bpas_pkg::qcnt_t'(push) - bpas_pkg::qcnt_t'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bpas_back.sv]
// ----------------------------------------------------------------------------
// Bit-packed array store: back end
// Clears the word RAM after reset, then carries out queued commands as reads
// or read-modify-write writes on one or two words and registers read results.
// ----------------------------------------------------------------------------
`default_nettype none

module bpas_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bpas_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_read_value
);

  bpas_pkg::back_state_t state_r, state_nxt;
  bpas_pkg::addr_t       clr_cnt_r, clr_cnt_nxt;
  bpas_pkg::cmd_t        cmd_r;
  bpas_pkg::data_t       d0_r;
  logic                  out_valid_r, out_valid_nxt;
  bpas_pkg::data_t       out_data_r;

  // RAM port signals.
  logic            ram_we, ram_re;
  bpas_pkg::addr_t ram_waddr, ram_raddr;
  bpas_pkg::data_t ram_wdata, ram_rdata;

  // Sequencer controls.
  logic            cmd_load, d0_load, res_load, clr_inc;
  bpas_pkg::data_t res_value;

  // Datapath.
  logic            out_free, is_write;
  bpas_pkg::addr_t word_addr, next_addr;
  bpas_pkg::off_t  hi_shift;
  bpas_pkg::data_t lomask, m0, v0, new0, new1;
  bpas_pkg::data_t raw_near, raw_far, raw, masked, top_bit, read_result;

  bpas_ram #(
    .WIDTH (bpas_pkg::DATA_W),
    .DEPTH (bpas_pkg::WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign is_write  = cmd_r.op == bpas_pkg::OP_WRITE;
  assign word_addr = bpas_pkg::addr_t'(cmd_r.word);
  assign next_addr = word_addr + bpas_pkg::addr_t'(1);
  assign clearing  = state_r == bpas_pkg::ST_CLEAR;

  // Write merge: a split element keeps its upper bits in the first word and
  // its low left-over bits at the bottom of the next word.
  assign lomask   = ~(bpas_pkg::ALL_ONES << cmd_r.lo);
  assign hi_shift = cmd_r.straddle ? cmd_r.lo : '0;
  assign m0       = (cmd_r.mask >> hi_shift) << cmd_r.off;
  assign v0       = (cmd_r.value >> hi_shift) << cmd_r.off;
  assign new0     = (ram_rdata & ~m0) | v0;
  assign new1     = (ram_rdata & ~lomask) | (cmd_r.value & lomask);

  // Read extraction with optional sign extension from the element's top bit.
  assign raw_near    = ram_rdata >> cmd_r.off;
  assign raw_far     = ((d0_r >> cmd_r.off) << cmd_r.lo) | (ram_rdata & lomask);
  assign raw         = (state_r == bpas_pkg::ST_SECOND) ? raw_far : raw_near;
  assign masked      = raw & cmd_r.mask;
  assign top_bit     = cmd_r.mask ^ (cmd_r.mask >> 1);
  assign read_result = (cmd_r.sgn && (|(masked & top_bit))) ?
                       (masked | ~cmd_r.mask) : masked;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpas_pkg::ST_CLEAR: begin
        if (clr_cnt_r == bpas_pkg::CLEAR_LAST) begin
          state_nxt = bpas_pkg::ST_IDLE;
        end
      end
      bpas_pkg::ST_IDLE: begin
        if (q_valid && !q_cmd.skip) begin
          state_nxt = bpas_pkg::ST_FIRST;
        end
      end
      bpas_pkg::ST_FIRST: begin
        if (cmd_r.straddle) begin
          state_nxt = bpas_pkg::ST_SECOND;
        end else if (is_write || out_free) begin
          state_nxt = bpas_pkg::ST_IDLE;
        end
      end
      bpas_pkg::ST_SECOND: begin
        if (is_write || out_free) begin
          state_nxt = bpas_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_addr;
    ram_wdata = new0;
    ram_re    = 1'b0;
    ram_raddr = bpas_pkg::addr_t'(q_cmd.word);
    q_pop     = 1'b0;
    cmd_load  = 1'b0;
    d0_load   = 1'b0;
    res_load  = 1'b0;
    res_value = read_result;
    clr_inc   = 1'b0;
    unique case (state_r)
      bpas_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        clr_inc   = 1'b1;
      end
      bpas_pkg::ST_IDLE: begin
        if (q_valid) begin
          priority if (!q_cmd.skip) begin
            q_pop    = 1'b1;
            cmd_load = 1'b1;
            ram_re   = 1'b1;
          end else if (q_cmd.op == bpas_pkg::OP_WRITE) begin
            // A write beyond the array is dropped.
            q_pop = 1'b1;
          end else if (out_free) begin
            // A read beyond the array returns zero.
            q_pop     = 1'b1;
            res_load  = 1'b1;
            res_value = '0;
          end
        end
      end
      bpas_pkg::ST_FIRST: begin
        d0_load = 1'b1;
        if (cmd_r.straddle) begin
          ram_re    = 1'b1;
          ram_raddr = next_addr;
          ram_we    = is_write;
        end else if (is_write) begin
          ram_we = 1'b1;
        end else begin
          res_load = out_free;
        end
      end
      bpas_pkg::ST_SECOND: begin
        ram_waddr = next_addr;
        ram_wdata = new1;
        if (is_write) begin
          ram_we = 1'b1;
        end else begin
          res_load = out_free;
        end
      end
    endcase
  end

  // Control registers.
  assign clr_cnt_nxt   = clr_inc ? clr_cnt_r + bpas_pkg::addr_t'(1) : clr_cnt_r;
  assign out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpas_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_r <= q_cmd;
    end
    if (d0_load) begin
      d0_r <= ram_rdata;
    end
    if (res_load) begin
      out_data_r <= res_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

endmodule

`default_nettype wire

[rtl/core/bit_packed_array_store_top.sv]
// Results: a read result is registered after the RAM read of its word, and of
// the next word too when the element is split over two; a write gives none.
// Requests wait in a queue; the back end takes the next one only when it is
// idle, running each as a read, or a read-then-write, on the single word RAM.
// Reset: synchronous; afterwards a clearing pass zeroes all 1025 words of the
// word RAM while in_ready stays low (configuration writes are still taken).
// ----------------------------------------------------------------------------
// Bit-packed array store: top level
// Elements of a configurable width packed into 64-bit words, with a
// configuration port for the element width and signed mode.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packed_array_store_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [9:0]                    in_element_index,
  input  logic signed [63:0]            in_write_value,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [63:0]            out_read_value,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpas_pkg::PADDR_W-1:0]  paddr,
  input  logic [bpas_pkg::PDATA_W-1:0]  pwdata,
  output logic [bpas_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  bpas_pkg::width_t   width_r, width_nxt;
  logic               signed_r, signed_nxt;
  logic               cfg_wr;
  bpas_pkg::reg_idx_t reg_sel;

  logic               q_valid, q_pop, clearing;
  bpas_pkg::cmd_t     q_cmd;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = bpas_pkg::reg_idx_t'(paddr[bpas_pkg::PADDR_W-1]);

  always_comb begin
    width_nxt  = width_r;
    signed_nxt = signed_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        bpas_pkg::REG_STORED_WIDTH: width_nxt  = pwdata[bpas_pkg::WIDTH_W-1:0];
        bpas_pkg::REG_SIGNED_MODE:  signed_nxt = pwdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bpas_pkg::WIDTH_RESET;
      signed_r <= bpas_pkg::SIGNED_RESET;
    end else begin
      width_r  <= width_nxt;
      signed_r <= signed_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      bpas_pkg::REG_STORED_WIDTH: prdata = bpas_pkg::pdata_t'(width_r);
      bpas_pkg::REG_SIGNED_MODE:  prdata = bpas_pkg::pdata_t'(signed_r);
    endcase
  end

  bpas_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_element_index (in_element_index),
    .in_write_value   (in_write_value),
    .stored_width     (width_r),
    .signed_mode      (signed_r),
    .clearing         (clearing),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  bpas_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value)
  );

endmodule

`default_nettype wire

[rtl/core/bpas_checker.sv]
// ----------------------------------------------------------------------------
// Bit-packed array store: port checker
// Watches the top level's ports for reset, result and register behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bit_packed_array_store_top_macros.svh"

module bpas_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [63:0]                  out_read_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpas_pkg::PADDR_W-1:0] paddr,
  input  logic [bpas_pkg::PDATA_W-1:0] pwdata,
  input  logic [bpas_pkg::PDATA_W-1:0] prdata
);

  // No request is taken in the first cycle after reset: the RAM is clearing.
  `BPAS_ASSERT_NOW(a_clear_blocks_requests, !$past(rst_n), !in_ready, "request taken during clear")

  // A stalled result stays put until it is taken.
  `BPAS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_read_value), "result dropped or changed while stalled")

  // A width write is read back on the next cycle.
  `BPAS_ASSERT_NEXT(a_width_readback, psel && penable && pwrite && !paddr[2], paddr[2] || prdata[6:0] == $past(pwdata[6:0]), "width register read-back mismatch")

  // A signed-mode write is read back on the next cycle.
  `BPAS_ASSERT_NEXT(a_signed_readback, psel && penable && pwrite && paddr[2], !paddr[2] || prdata[0] == $past(pwdata[0]), "signed mode read-back mismatch")

endmodule

bind bit_packed_array_store_top bpas_checker u_checker (.*);

`default_nettype wire
